[rtl/wpf_pkg.sv]
// Package for the waveform period finder: field widths, defaults and the
// payload and cell-control struct types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpf_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W = 8;
   localparam int OFFSET_W = 12;
   localparam int TOL_W    = 8;

   // Defaults for the top-level parameters.
   localparam int WINDOW_DEFAULT  = 8;
   localparam int MAX_LEN_DEFAULT = 4096;

   // Tolerance after reset.
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

   // One input item.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [OFFSET_W-1:0] match_offset;
      logic                overflow;
   } rsp_type;

   // Per-cell controls for one clock.
   typedef struct packed {
      logic shift;
      logic ref_we;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/wpf_cell.sv]
// One cell of the comparison chain: one delay-line tap, one reference sample,
// and a tolerance compare whose result is ANDed into the chain. Uses wpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpf_cell (
   input  wire                          clock,
   input  wpf_pkg::cell_ctrl_type       ctrl,
   input  wire [wpf_pkg::SAMPLE_W-1:0]  sample_in,
   input  wire [wpf_pkg::SAMPLE_W-1:0]  ref_data,
   input  wire [wpf_pkg::TOL_W-1:0]     tolerance,
   input  wire                          match_in,
   output logic [wpf_pkg::SAMPLE_W-1:0] sample_out,
   output logic                         match_out
);
   import wpf_pkg::*;

   logic [SAMPLE_W-1:0] tap_ff;
   logic [SAMPLE_W-1:0] tap_in;
   logic [SAMPLE_W-1:0] ref_ff;
   logic [SAMPLE_W-1:0] ref_in;
   logic [SAMPLE_W-1:0] diff;

   // The tap takes its neighbor's sample on every transfer below the length limit;
   // the reference sample is written once, while the stream start is being captured.
   always_comb begin
      tap_in = ctrl.shift  ? sample_in : tap_ff;
      ref_in = ctrl.ref_we ? ref_data  : ref_ff;
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
      ref_ff <= ref_in;
   end

   // Absolute difference against the reference, folded into the chain.
   always_comb begin
      diff       = (ref_ff > tap_ff) ? (ref_ff - tap_ff) : (tap_ff - ref_ff);
      match_out  = match_in && (diff <= tolerance);
      sample_out = tap_ff;
   end

endmodule

`default_nettype wire

[rtl/waveform_period_finder.sv]
// Waveform period finder: accepts one sample per cycle, back to back, while
// the output is not stalled, and gives one result the cycle after the sample
// marked last is taken. A window compare runs in the cycle after its sample,
// across WINDOW cells in one chain; that chain sets the clock path, not the rate.
// Reset (synchronous) clears counters, flags and the output stage and sets the
// tolerance to 1; the delay line and reference cells hold stale data.
`timescale 1ns / 1ps
`default_nettype none

module waveform_period_finder #(
   parameter int WINDOW  = wpf_pkg::WINDOW_DEFAULT,
   parameter int MAX_LEN = wpf_pkg::MAX_LEN_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wpf_pkg::req_type         req_payload,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output wpf_pkg::rsp_type         rsp_payload,
   input  wire                      rsp_stall,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [wpf_pkg::TOL_W-1:0] csr_data
);
   import wpf_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int OFS_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

   logic [TOL_W-1:0]    tolerance_ff, tolerance_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OFFSET_W-1:0] best_ff, best_in;
   logic                overflow_ff, overflow_in;
   logic                check_valid_ff, check_valid_in;
   logic [OFFSET_W-1:0] check_offset_ff, check_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;

   logic                take;
   logic                take_last;
   logic                below_max;
   logic                start_check;
   logic [OFS_W-1:0]    offset_wide;
   logic [OFFSET_W-1:0] best_now;
   logic                window_match;

   cell_ctrl_type       cell_ctrl [WINDOW];
   logic [SAMPLE_W-1:0] tap [WINDOW];
   logic                match_link [WINDOW+1];

   // Handshakes: the output register frees itself when its transfer completes.
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign take        = req_valid && !req_stall;
   assign take_last   = take && req_payload.last;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Stream position and window bookkeeping.
   always_comb begin
      below_max   = 32'(count_ff) < MAX_LEN;
      start_check = take && below_max && !req_payload.last
                    && (32'(count_ff) >= WINDOW) && (32'(count_ff) + 1 < MAX_LEN);
      offset_wide = OFS_W'(count_ff) - OFS_W'(WINDOW - 1);
      check_offset_in = offset_wide[OFFSET_W-1:0];
   end

   // The pending compare from the previous transfer resolves this cycle.
   assign window_match = match_link[0];
   assign best_now     = (check_valid_ff && window_match) ? check_offset_ff : best_ff;

   // Next-state logic for counters, flags and the result register.
   always_comb begin
      tolerance_in   = (csr_valid && csr_ready) ? csr_data : tolerance_ff;
      check_valid_in = start_check;

      if (take_last) begin
         count_in = '0;
      end else if (take && below_max) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end

      best_in = take_last ? '0 : best_now;

      if (take_last) begin
         overflow_in = 1'b0;
      end else if (take && !below_max) begin
         overflow_in = 1'b1;
      end else begin
         overflow_in = overflow_ff;
      end

      if (take_last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_payload_in = rsp_payload_ff;
      if (take_last) begin
         rsp_payload_in.match_offset = best_now;
         rsp_payload_in.overflow     = overflow_ff || !below_max;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= TOL_RESET;
         count_ff       <= '0;
         best_ff        <= '0;
         overflow_ff    <= 1'b0;
         check_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tolerance_ff   <= tolerance_in;
         count_ff       <= count_in;
         best_ff        <= best_in;
         overflow_ff    <= overflow_in;
         check_valid_ff <= check_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      check_offset_ff <= check_offset_in;
      rsp_payload_ff  <= rsp_payload_in;
   end

   // Chain of cells: samples move toward cell 0, the match flag ripples down.
   assign match_link[WINDOW] = 1'b1;

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      logic [SAMPLE_W-1:0] from_neighbor;

      if (k == WINDOW - 1) begin : g_head
         assign from_neighbor = req_payload.sample;
      end else begin : g_body
         assign from_neighbor = tap[k+1];
      end

      always_comb begin
         cell_ctrl[k].shift  = take && below_max;
         cell_ctrl[k].ref_we = take && below_max && (32'(count_ff) == k);
      end

      wpf_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[k]),
         .sample_in  (from_neighbor),
         .ref_data   (req_payload.sample),
         .tolerance  (tolerance_ff),
         .match_in   (match_link[k+1]),
         .sample_out (tap[k]),
         .match_out  (match_link[k])
      );
   end

   // A result appears only after a transfer of a sample marked last.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take_last))
      else $error("result raised without a last sample");

   // A pending compare always has a full window behind it.
   a_check_window: assert property (@(posedge clock) disable iff (reset)
      check_valid_ff |-> (32'(count_ff) > WINDOW))
      else $error("window compare pending before the window filled");

   // The sample count never passes the stream limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_LEN)
      else $error("sample count beyond limit");

   // A dropped sample can only happen once the stream is full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (32'(count_ff) == MAX_LEN))
      else $error("overflow flagged before the stream filled");

endmodule

`default_nettype wire

[bench/waveform_period_finder_tb.sv]
// Self-checking testbench for the waveform period finder: sample streams in,
// one offset result per stream out, tolerance set through the csr port.
// Depends on wpf_pkg and waveform_period_finder from the rtl folder.
`timescale 1ns / 1ps

module waveform_period_finder_tb;
   import wpf_pkg::*;

   localparam int WINDOW  = WINDOW_DEFAULT;
   localparam int MAX_LEN = MAX_LEN_DEFAULT;
   localparam int PHASES  = 5;
   localparam int PHASE_SAMPLES = 380;
   localparam int SETTLE_CYCLES = 4;
   localparam int PRINT_CAP = 60;

   // Shapes of generated sample streams.
   typedef enum int {
      KIND_NOISE,
      KIND_EXACT,
      KIND_JITTER
   } stream_kind_type;

   // One row of the directed table; want is meaningful only when typed is set.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } directed_row_type;

   // Single-sample stream, a one-step repeat at tolerance 1, and a two-step
   // repeat where odd offsets miss by two.
   localparam directed_row_type DIRECTED_ROWS [25] = '{
      {8'h00, 1'b1, 1'b1, 12'd0, 1'b0},
      {8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h81, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h81, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h81, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h81, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h80, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'h81, 1'b1, 1'b1, 12'd1, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFD, 1'b0, 1'b0, 12'd0, 1'b0},
      {8'hFF, 1'b1, 1'b1, 12'd4, 1'b0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   req_type          req_payload = '0;
   logic             req_stall;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             rsp_stall = 1'b0;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [TOL_W-1:0] csr_data = '0;

   // Idle and stall rates of the current phase, in percent.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int samples_sent = 0;

   // Predicted block state.
   int                  tolerance_now = int'(TOL_RESET);
   logic [SAMPLE_W-1:0] ref_window [WINDOW];
   logic [SAMPLE_W-1:0] recent_samples [WINDOW];
   int                  stream_len = 0;
   int                  latest_offset = 0;
   logic                dropped_flag = 1'b0;

   // Results still owed by the block, oldest first.
   rsp_type pending_offsets [$];

   waveform_period_finder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_payload(req_payload),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   // Takes one sample into the predicted state; returns 1 with the result
   // when the sample ends the stream.
   function automatic bit advance_period_search(input req_type item, output rsp_type res);
      int  k;
      int  diff;
      bit  hit;
      res = '0;
      if (stream_len < MAX_LEN) begin
         if (stream_len < WINDOW) begin
            ref_window[stream_len] = item.sample;
         end
         for (k = 0; k < WINDOW - 1; k++) begin
            recent_samples[k] = recent_samples[k + 1];
         end
         recent_samples[WINDOW - 1] = item.sample;
         // The window ending here starts WINDOW - 1 samples back; it may not
         // hold the final sample of the stream.
         if (!item.last && stream_len >= WINDOW && stream_len + 1 < MAX_LEN) begin
            hit = 1'b1;
            for (k = 0; k < WINDOW; k++) begin
               diff = int'(ref_window[k]) - int'(recent_samples[k]);
               if (diff < 0) begin
                  diff = -diff;
               end
               if (diff > tolerance_now) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               latest_offset = stream_len - WINDOW + 1;
            end
         end
         stream_len++;
      end else begin
         dropped_flag = 1'b1;
      end
      if (!item.last) begin
         return 1'b0;
      end
      res.match_offset = latest_offset[OFFSET_W-1:0];
      res.overflow = dropped_flag;
      stream_len = 0;
      latest_offset = 0;
      dropped_flag = 1'b0;
      return 1'b1;
   endfunction

   // Offers one sample after a random gap and holds it until the transfer.
   task automatic send_sample(input req_type item, input logic use_typed,
                              input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      samples_sent++;
      if (advance_period_search(item, predicted)) begin
         pending_offsets.push_back(use_typed ? typed_rsp : predicted);
      end
   endtask

   // Sends one stream: a random motif repeated exactly, repeated with jitter
   // around the tolerance, or plain noise.
   task automatic send_stream(input int len, input stream_kind_type kind);
      logic [SAMPLE_W-1:0] motif [16];
      int                  period;
      int                  noise;
      int                  value;
      int                  k;
      req_type             item;
      period = $urandom_range(1, 16);
      for (k = 0; k < 16; k++) begin
         motif[k] = $urandom_range(0, 255);
      end
      for (k = 0; k < len; k++) begin
         value = motif[k % period];
         if (kind == KIND_NOISE) begin
            value = $urandom_range(0, 255);
         end else if (kind == KIND_JITTER) begin
            noise = $urandom_range(0, tolerance_now + 1);
            value = $urandom_range(1) ? value + noise : value - noise;
            if (value < 0) begin
               value = 0;
            end
            if (value > 255) begin
               value = 255;
            end
         end
         item.sample = value[SAMPLE_W-1:0];
         item.last = (k == len - 1);
         send_sample(item, 1'b0, '0);
      end
   endtask

   // Lowers valid and waits until every owed result has been taken.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_offsets.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      tolerance_now = int'(value);
   endtask

   // Receiver side: random stall at the phase's rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare every result transfer against the oldest owed result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_offsets.size() == 0) begin
            report_mismatch($sformatf("unexpected result offset %0d overflow %0b",
                                      rsp_payload.match_offset, rsp_payload.overflow));
         end else begin
            want = pending_offsets.pop_front();
            if (rsp_payload.match_offset !== want.match_offset) begin
               report_mismatch($sformatf("match_offset %0d, expected %0d",
                                         rsp_payload.match_offset, want.match_offset));
            end
            if (rsp_payload.overflow !== want.overflow) begin
               report_mismatch($sformatf("overflow %0b, expected %0b",
                                         rsp_payload.overflow, want.overflow));
            end
         end
      end
   end

   // Main sequence: reset, directed rows, then one random phase per setting.
   initial begin
      int              phase;
      int              row;
      int              pick;
      int              len;
      int              phase_end;
      bit              paused;
      stream_kind_type kind;
      for (row = 0; row < WINDOW; row++) begin
         ref_window[row] = '0;
         recent_samples[row] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < 25; row++) begin
         send_sample(DIRECTED_ROWS[row].item, DIRECTED_ROWS[row].typed,
                     DIRECTED_ROWS[row].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_until_idle();
            repeat (SETTLE_CYCLES) @(posedge clock);
            case (phase)
               1: write_tolerance(8'd0);
               2: write_tolerance(8'd255);
               3: write_tolerance(TOL_W'($urandom_range(2, 20)));
               default: write_tolerance(TOL_W'($urandom_range(0, 255)));
            endcase
         end
         case (phase)
            1: begin
               send_idle_pct = 88;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 88;
            end
            3: begin
               send_idle_pct = 35;
               recv_stall_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         phase_end = samples_sent + PHASE_SAMPLES;
         paused = 1'b0;
         while (samples_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
               len = $urandom_range(1, WINDOW + 1);
            end else if (pick < 90) begin
               len = $urandom_range(WINDOW + 2, 40);
            end else begin
               len = $urandom_range(41, 200);
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
               kind = KIND_NOISE;
            end else if (pick < 55) begin
               kind = KIND_EXACT;
            end else begin
               kind = KIND_JITTER;
            end
            send_stream(len, kind);
            // Halfway through the receiver-stall phase, hold off until the
            // block has handed over everything it owes.
            if (phase == 2 && !paused && samples_sent > phase_end - PHASE_SAMPLES / 2) begin
               wait_until_idle();
               paused = 1'b1;
            end
         end
         // One stream running past the length limit: the search stops at the limit
         // and the last mark lands on a dropped sample.
         if (phase == 0) begin
            send_stream(MAX_LEN + 4, KIND_EXACT);
         end
      end

      wait_until_idle();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("waveform_period_finder_tb: done, clean");
      end else begin
         $display("waveform_period_finder_tb: done, errors");
      end
      $finish;
   end

   // Watchdog: the slowest correct run takes well under a tenth of this.
   initial begin
      #5_000_000;
      $display("waveform_period_finder_tb: done, errors");
      $finish;
   end

endmodule
